// ===== rtl/pfbd_pkg.sv =====
// shared types and constants for the potentiometer filter and button debounce block
// no dependencies
`default_nettype none

package pfbd_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 10;
    localparam int POS_BITS            = 8;
    localparam int CNT_BITS            = 2;

    localparam logic [POS_BITS-1:0] SPAN_RESET    = 8'd14;
    localparam logic [CNT_BITS-1:0] DEBOUNCE_LAST = 2'd3;

    // filter rounding term and shift
    localparam int FILTER_ROUND = 4;
    localparam int FILTER_SHIFT = 3;

    // filter stage result
    typedef struct packed {
        logic                changed;
        logic [POS_BITS-1:0] position;
    } filt_res_t;

endpackage

`default_nettype wire

// ===== rtl/pot_filter_and_button_debounce.sv =====
// potentiometer low-pass filter and button debounce, top level
// items flow through input register, filter/scale/debounce and result register
// throughput: one item per cycle while m_axis_tready does not stall the result register
// reset (rst_n, async, active low): filter level, last position, debounced level (pressed)
// and mismatch count cleared, span set to 14, both pipeline stages emptied
// depends on pfbd_pkg, pfbd_filter, pfbd_debounce
`default_nettype none

module pot_filter_and_button_debounce #(
    parameter int SAMPLE_BITS = pfbd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // configuration: position_span
    input  wire logic                                cfg_we,
    input  wire logic [pfbd_pkg::POS_BITS-1:0]       cfg_wdata,

    // input items
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // adc_sample, button_level, zero fill
    input  wire logic [((SAMPLE_BITS+8)/8)*8-1:0]    s_axis_tdata,

    // result items
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // position_changed, position, press_event, zero fill
    output logic [15:0]                              m_axis_tdata
);

    localparam int OUT_BITS = pfbd_pkg::POS_BITS + 2;

    // span register
    logic [pfbd_pkg::POS_BITS-1:0] span_reg;

    // input stage
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_button_reg;

    // result stage
    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    out_data_reg;
    logic [OUT_BITS-1:0]    out_data_next;

    logic                   out_load;
    logic                   in_take;
    logic                   press;
    pfbd_pkg::filt_res_t    filt_res;

    // result register frees when empty or being taken
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    // input register frees when empty or moving on
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= pfbd_pkg::SPAN_RESET;
        end
        else if (cfg_we)
        begin
            span_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_button_reg <= s_axis_tdata[SAMPLE_BITS];
        end
    end

    // filter state moves on only when the item enters the result register
    pfbd_filter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (out_load),
        .sample (in_sample_reg),
        .span   (span_reg),
        .res    (filt_res)
    );

    pfbd_debounce u_debounce (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (out_load),
        .level  (in_button_reg),
        .press  (press)
    );

    assign out_data_next = {press, filt_res.position, filt_res.changed};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_data_reg);

endmodule

`default_nettype wire

// ===== rtl/pfbd_filter.sv =====
// low-pass filter, inverted scaling to a wheel position and change detect
// depends on pfbd_pkg
`default_nettype none

module pfbd_filter #(
    parameter int SAMPLE_BITS = pfbd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           update,
    input  wire logic [SAMPLE_BITS-1:0]         sample,
    input  wire logic [pfbd_pkg::POS_BITS-1:0]  span,
    output pfbd_pkg::filt_res_t                 res
);

    localparam int DW = SAMPLE_BITS + 2;
    localparam int IW = SAMPLE_BITS + 1;
    localparam int PW = IW + pfbd_pkg::POS_BITS;

    logic [SAMPLE_BITS-1:0]        level_reg;
    logic [SAMPLE_BITS-1:0]        level_next;
    logic [pfbd_pkg::POS_BITS-1:0] last_pos_reg;

    logic signed [DW-1:0]          diff;
    logic signed [DW-1:0]          step;
    logic        [DW-1:0]          sum;
    logic        [IW-1:0]          inv;
    logic        [PW-1:0]          prod;
    logic [pfbd_pkg::POS_BITS-1:0] pos;

    always_comb
    begin
        // y + floor((x - y + round) / 8)
        diff = DW'({2'b00, sample}) - DW'({2'b00, level_reg})
               + DW'(pfbd_pkg::FILTER_ROUND);
        step = diff >>> pfbd_pkg::FILTER_SHIFT;
        sum  = DW'({2'b00, level_reg}) + step;
        level_next = sum[SAMPLE_BITS-1:0];

        // full scale minus level, times span, back down by the sample width
        inv  = (IW'(1) << SAMPLE_BITS) - {1'b0, level_next};
        prod = PW'(inv) * PW'(span);
        pos  = prod[SAMPLE_BITS +: pfbd_pkg::POS_BITS];

        res.changed  = (pos != last_pos_reg);
        res.position = pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            last_pos_reg <= '0;
        end
        else if (update)
        begin
            level_reg    <= level_next;
            last_pos_reg <= pos;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pfbd_debounce.sv =====
// four-sample button debouncer with press detect
// depends on pfbd_pkg
`default_nettype none

module pfbd_debounce (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic update,
    input  wire logic level,
    output logic      press
);

    logic                          stable_reg;
    logic                          stable_next;
    logic [pfbd_pkg::CNT_BITS-1:0] cnt_reg;
    logic [pfbd_pkg::CNT_BITS-1:0] cnt_next;

    always_comb
    begin
        stable_next = stable_reg;
        cnt_next    = '0;
        press       = 1'b0;
        priority if (cnt_reg >= pfbd_pkg::DEBOUNCE_LAST)
        begin
            if (level != stable_reg)
            begin
                stable_next = level;
                press       = !level;
            end
        end
        else if (level != stable_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            // matching sample, run starts over
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (update)
        begin
            stable_reg <= stable_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/pfbd_checker.sv =====
// result checker for the potentiometer filter and button debounce block
// watches the configuration, input and result channels, predicts and compares
// depends on pfbd_pkg
`timescale 1ns / 1ps

module pfbd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pfbd_pkg::POS_BITS-1:0] cfg_wdata,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    // adc_sample, button_level, zero fill
    input  wire logic [15:0]                   s_axis_tdata,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // position_changed, position, press_event, zero fill
    input  wire logic [15:0]                   m_axis_tdata,
    output int                                 fail_count,
    output int                                 pending_count
);

    localparam int ADC_BITS   = pfbd_pkg::SAMPLE_BITS_DEFAULT;
    localparam int FULL_LEVEL = 1 << ADC_BITS;

    typedef struct {
        logic                          changed;
        logic [pfbd_pkg::POS_BITS-1:0] position;
        logic                          press;
    } wheel_result_t;

    wheel_result_t                 wheel_results_q[$];
    logic [pfbd_pkg::POS_BITS-1:0] span_reg;
    logic [ADC_BITS-1:0]           lp_level;
    logic [pfbd_pkg::POS_BITS-1:0] prev_pos;
    logic                          btn_stable;
    logic [pfbd_pkg::CNT_BITS-1:0] btn_run;
    int                            err_cnt;

    initial
    begin
        err_cnt = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // one filter, scale and debounce step on the mirrored state
    function automatic wheel_result_t filter_and_debounce(input logic [ADC_BITS-1:0] adc,
                                                          input logic btn);
        wheel_result_t res;
        int            diff;
        int            scaled;
        diff     = int'(adc) - int'(lp_level) + pfbd_pkg::FILTER_ROUND;
        lp_level = ADC_BITS'(int'(lp_level) + (diff >>> pfbd_pkg::FILTER_SHIFT));
        scaled   = ((FULL_LEVEL - int'(lp_level)) * int'(span_reg)) >>> ADC_BITS;
        res.position = scaled[pfbd_pkg::POS_BITS-1:0];
        res.changed  = (res.position != prev_pos);
        prev_pos     = res.position;
        res.press    = 1'b0;
        if (btn_run >= pfbd_pkg::DEBOUNCE_LAST)
        begin
            if (btn != btn_stable)
            begin
                btn_stable = btn;
                res.press  = !btn;
            end
            btn_run = '0;
        end
        else if (btn != btn_stable)
        begin
            btn_run = btn_run + 1'b1;
        end
        else
        begin
            btn_run = '0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        wheel_result_t want;
        if (!rst_n)
        begin
            wheel_results_q.delete();
            span_reg   = pfbd_pkg::SPAN_RESET;
            lp_level   = '0;
            prev_pos   = '0;
            btn_stable = 1'b0;
            btn_run    = '0;
        end
        else
        begin
            // result side first, a new input item cannot reach the output in the same cycle
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (wheel_results_q.size() == 0)
                begin
                    report_mismatch("result item with nothing expected",
                                    int'(m_axis_tdata), 0);
                end
                else
                begin
                    want = wheel_results_q.pop_front();
                    if (m_axis_tdata[0] !== want.changed)
                        report_mismatch("position_changed", int'(m_axis_tdata[0]),
                                        int'(want.changed));
                    if (m_axis_tdata[8:1] !== want.position)
                        report_mismatch("position", int'(m_axis_tdata[8:1]),
                                        int'(want.position));
                    if (m_axis_tdata[9] !== want.press)
                        report_mismatch("press_event", int'(m_axis_tdata[9]),
                                        int'(want.press));
                end
            end
            if (cfg_we)
                span_reg = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                wheel_results_q.push_back(filter_and_debounce(s_axis_tdata[ADC_BITS-1:0],
                                                              s_axis_tdata[ADC_BITS]));
        end
        fail_count    <= err_cnt;
        pending_count <= wheel_results_q.size();
    end

endmodule

// ===== tb/pot_filter_and_button_debounce_tb.sv =====
// testbench top for the potentiometer filter and button debounce block
// drives directed and random items over several span settings and idling phases
// depends on pfbd_pkg, pfbd_checker and the block itself
`timescale 1ns / 1ps

module pot_filter_and_button_debounce_tb;

    // settle time after draining, as margin for the block's input and result registers
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEMS_PER_PHASE = 200;

    logic                          clk;
    logic                          rst_n         = 1'b0;
    logic                          cfg_we        = 1'b0;
    logic [pfbd_pkg::POS_BITS-1:0] cfg_wdata     = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // adc_sample, button_level, zero fill
    logic [15:0]                   s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // position_changed, position, press_event, zero fill
    logic [15:0]                   m_axis_tdata;
    int                            fail_count;
    int                            pending_count;

    // idling odds in percent, changed per phase
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;

    // random stimulus shaping state: slowly moving wheel target, button runs
    int                  wheel_target   = 512;
    logic                btn_level      = 1'b0;
    int                  btn_run_left   = 0;

    pot_filter_and_button_debounce u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pfbd_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver back-pressure, one draw per cycle
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one item and hold it until the block takes it
    task automatic send_sample(input logic [9:0] adc, input logic btn);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, btn, adc};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop offering and wait for every expected result, then let the pipeline settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // span register write, only called with the block idle
    task automatic write_span(input logic [pfbd_pkg::POS_BITS-1:0] span);
        cfg_we    <= 1'b1;
        cfg_wdata <= span;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // wheel mostly hovers around a target that jumps now and then,
    // button mostly in clean runs long enough to debounce, with some bounce
    task automatic send_random(input int count);
        int   pick;
        int   level;
        logic btn;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                wheel_target = $urandom_range(1) ? 1023 : 0;
            else if (pick < 10)
                wheel_target = $urandom_range(1023);
            if ($urandom_range(9) == 0)
            begin
                level = $urandom_range(1023);
            end
            else
            begin
                level = wheel_target + int'($urandom_range(8)) - 4;
                if (level < 0)
                    level = 0;
                if (level > 1023)
                    level = 1023;
            end
            if (btn_run_left <= 0)
            begin
                btn_level    = ~btn_level;
                btn_run_left = ($urandom_range(4) == 0) ? $urandom_range(3, 1)
                                                        : $urandom_range(12, 4);
            end
            btn = btn_level;
            if ($urandom_range(19) == 0)
                btn = ~btn;
            btn_run_left--;
            send_sample(level[9:0], btn);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part at the reset span
        // three differing samples then a matching one: count falls back, no change
        send_sample(10'd1023, 1'b1);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd1023, 1'b0);
        // four released samples: debounced level goes high, no event
        send_sample(10'd1023, 1'b1);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd1023, 1'b1);
        // four pressed samples: press event on the fourth
        send_sample(10'd0, 1'b0);
        send_sample(10'd0, 1'b0);
        send_sample(10'd0, 1'b0);
        send_sample(10'd0, 1'b0);
        // held pressed, then bounce and release: no further press event
        send_sample(10'd0, 1'b0);
        send_sample(10'd1, 1'b1);
        send_sample(10'd1022, 1'b1);
        send_sample(10'd512, 1'b0);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd0, 1'b1);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd0, 1'b1);
        send_sample(10'd1023, 1'b1);

        // no idling, widest span
        wait_drained();
        write_span(8'd255);
        send_random(ITEMS_PER_PHASE);

        // sender mostly idle, narrowest non-zero span
        wait_drained();
        write_span(8'd1);
        send_idle_pct = 76;
        send_random(ITEMS_PER_PHASE);

        // receiver mostly stalling, zero span keeps the position at 0
        wait_drained();
        write_span(8'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        send_random(ITEMS_PER_PHASE);

        // both sides idling now and then, random span
        wait_drained();
        write_span(8'($urandom_range(254, 2)));
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        send_random(ITEMS_PER_PHASE);

        wait_drained();
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pfbd_pkg.sv
rtl/pfbd_filter.sv
rtl/pfbd_debounce.sv
rtl/pot_filter_and_button_debounce.sv
tb/pfbd_checker.sv
tb/pot_filter_and_button_debounce_tb.sv
